/* rtl/krt_pkg.sv */
// keyed record table: shared constants and the controller/datapath command and status types
// used by krt_ctrl, krt_dp and keyed_record_table
package krt_pkg;
  localparam int unsigned Capacity = 256;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdRemove = 3'd1;
  localparam logic [2:0] CmdModify = 3'd2;
  localparam logic [2:0] CmdFind = 3'd3;
  localparam logic [2:0] CmdSort = 3'd4;
  localparam logic [2:0] CmdClear = 3'd5;

  localparam logic [1:0] RegInitialSize = 2'd0;
  localparam logic [1:0] RegGrowthStep = 2'd1;

  // datapath operations
  typedef enum logic [3:0] {
    OpNone, OpStart, OpSrchInit, OpSrchRead, OpSrchEval, OpApply, OpAddWrite, OpRmRead,
    OpRmWrite, OpSortOuter, OpSortRead, OpSortEval, OpSortPlace, OpDone
  } krt_op_e;

  typedef struct packed {
    krt_op_e op;
  } krt_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       srch_done;
    logic       hit;
    logic       sort_outer_done;
    logic       sort_shift;
  } krt_sts_t;
endpackage

/* rtl/krt_ram.sv */
// generic single port ram with registered read
// no dependencies
module krt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/krt_ctrl.sv */
// keyed record table controller: sequences search, update and sort steps
// depends on krt_pkg
module krt_ctrl import krt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     out_free_i,
  input  krt_sts_t sts_i,
  output krt_cmd_t dp_cmd_o,
  output logic     busy_o
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDispatch = 4'd1;
  localparam logic [3:0] StSrchRead = 4'd2;
  localparam logic [3:0] StSrchEval = 4'd4;
  localparam logic [3:0] StApply = 4'd5;
  localparam logic [3:0] StRmWrite = 4'd7;
  localparam logic [3:0] StSortOuter = 4'd8;
  localparam logic [3:0] StSortEval = 4'd10;
  localparam logic [3:0] StDone = 4'd11;
  localparam logic [3:0] StSortRead = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    dp_cmd_o.op = OpNone;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          dp_cmd_o.op = OpStart;
          state_d = StDispatch;
        end
      end
      StDispatch: begin
        if (sts_i.cmd == CmdSort) begin
          state_d = StSortOuter;
        end else if (sts_i.cmd inside {CmdAdd, CmdRemove, CmdModify, CmdFind}) begin
          dp_cmd_o.op = OpSrchInit;
          state_d = StSrchRead;
        end else begin
          state_d = StDone;
        end
      end
      StSrchRead: begin
        if (sts_i.srch_done) begin
          state_d = StApply;
        end else begin
          dp_cmd_o.op = OpSrchRead;
          state_d = StSrchEval;
        end
      end
      StSrchEval: begin
        dp_cmd_o.op = OpSrchEval;
        state_d = StSrchRead;
      end
      StApply: begin
        if (sts_i.cmd == CmdAdd) begin
          dp_cmd_o.op = OpAddWrite;
          state_d = StDone;
        end else if (sts_i.cmd == CmdRemove && sts_i.hit) begin
          dp_cmd_o.op = OpRmRead;
          state_d = StRmWrite;
        end else begin
          dp_cmd_o.op = OpApply;
          state_d = StDone;
        end
      end
      StRmWrite: begin
        dp_cmd_o.op = OpRmWrite;
        state_d = StDone;
      end
      StSortOuter: begin
        dp_cmd_o.op = OpSortOuter;
        state_d = sts_i.sort_outer_done ? StDone : StSortRead;
      end
      StSortRead: begin
        dp_cmd_o.op = OpSortRead;
        state_d = StSortEval;
      end
      StSortEval: begin
        dp_cmd_o.op = OpSortEval;
        state_d = sts_i.sort_shift ? StSortRead : StSortOuter;
      end
      StDone: begin
        if (out_free_i) begin
          dp_cmd_o.op = OpDone;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);
endmodule

/* rtl/krt_dp.sv */
// keyed record table datapath: key and value memories, search and sort registers
// depends on krt_pkg and krt_ram
module krt_dp import krt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  krt_cmd_t          dp_cmd_i,
  input  logic [2:0]        cmd_i,
  input  logic [31:0]       key_i,
  input  logic [15:0]       val_i,
  input  logic              cfg_size_we_i,
  input  logic [15:0]       cfg_size_i,
  input  logic [7:0]        step_i,
  output krt_sts_t          sts_o,
  output logic              ok_o,
  output logic [CntW-1:0]   entries_o,
  output logic [15:0]       size_o,
  output logic [15:0]       found_o,
  output logic [15:0]       cmp_o
);
  logic [2:0]         cmd_q;
  logic [KeyBits-1:0] key_q;
  logic [15:0]        val_q;
  logic [CntW-1:0]    count_q;
  logic [15:0]        size_q;
  logic               sorted_q;
  logic               ok_q;
  logic [15:0]        found_q, cmp_q;
  // search
  logic [CntW:0]      lo_q, hi_q;  // signed-ish window, hi may be -1
  logic [CntW-1:0]    pos_q;
  logic               done_q, hit_q;
  // sort
  logic [CntW-1:0]    i_q, j_q;    // j points one above the compared slot
  logic [KeyBits-1:0] sk_q;
  logic [15:0]        sv_q;
  // memory ports
  logic               we;
  logic [IdxW-1:0]    addr;
  logic [KeyBits-1:0] wkey, rkey;
  logic [15:0]        wval, rval;
  // last probed record of a search
  logic [KeyBits-1:0] rkey_hold_q;
  logic [15:0]        rval_hold_q;

  krt_ram #(.Width(KeyBits), .Depth(Capacity)) u_keys (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wkey), .rdata_o(rkey));
  krt_ram #(.Width(16), .Depth(Capacity)) u_vals (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wval), .rdata_o(rval));

  logic [CntW:0] mid;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  function automatic logic [15:0] sat1(input logic [15:0] a);
    sat1 = (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

  // last key tracked through ram reads during a search (probe of last slot), used by add
  logic [KeyBits-1:0] last_key_q;
  logic               have_last_q;

  always_comb begin
    we = 1'b0;
    addr = '0;
    wkey = key_q;
    wval = val_q;
    case (dp_cmd_i.op)
      OpSrchRead: addr = sorted_q ? mid[IdxW-1:0] : lo_q[IdxW-1:0];
      OpAddWrite: begin
        we = ~hit_q && (count_q != CntW'(Capacity));
        addr = count_q[IdxW-1:0];
      end
      OpApply: begin
        we = (cmd_q == CmdModify) && hit_q;
        addr = pos_q[IdxW-1:0];
        wkey = rkey_hold_q;
      end
      OpRmRead: addr = IdxW'(count_q - CntW'(1));
      OpRmWrite: begin
        we = 1'b1;
        addr = pos_q[IdxW-1:0];
        wkey = rkey;
        wval = rval;
      end
      OpSortOuter: addr = i_q[IdxW-1:0];
      OpSortRead: addr = IdxW'(j_q - CntW'(1));
      OpSortEval: begin
        we = 1'b1;
        addr = (rkey > sk_q && j_q != '0) ? j_q[IdxW-1:0] : j_q[IdxW-1:0];
        if (j_q != '0 && rkey > sk_q) begin
          wkey = rkey;
          wval = rval;
        end else begin
          wkey = sk_q;
          wval = sv_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == OpStart) begin
      cmd_q <= cmd_i;
      key_q <= key_i[KeyBits-1:0];
      val_q <= val_i;
    end
    if (dp_cmd_i.op == OpSrchEval) begin
      rkey_hold_q <= rkey;
      rval_hold_q <= rval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      size_q <= 16'd8;
      sorted_q <= 1'b1;
      ok_q <= 1'b0;
      found_q <= '0;
      cmp_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      pos_q <= '0;
      done_q <= 1'b0;
      hit_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      sk_q <= '0;
      sv_q <= '0;
      last_key_q <= '0;
      have_last_q <= 1'b0;
    end else begin
      if (cfg_size_we_i) begin
        size_q <= cfg_size_i;
      end
      case (dp_cmd_i.op)
        OpStart: begin
          ok_q <= 1'b0;
          found_q <= '0;
          cmp_q <= '0;
          i_q <= CntW'(1);
          have_last_q <= 1'b0;
        end
        OpSrchInit: begin
          lo_q <= '0;
          hi_q <= {1'b0, count_q} - 1'b1;
          hit_q <= 1'b0;
          done_q <= (count_q == '0);
        end
        OpSrchEval: begin
          if (sorted_q) begin
            if (rkey == key_q) begin
              cmp_q <= sat1(cmp_q);
              hit_q <= 1'b1;
              pos_q <= mid[CntW-1:0];
              done_q <= 1'b1;
            end else begin
              cmp_q <= sat1(sat1(cmp_q));
              if (rkey > key_q) begin
                hi_q <= mid - 1'b1;
                done_q <= $signed(lo_q) > $signed(mid - 1'b1);
              end else begin
                lo_q <= mid + 1'b1;
                done_q <= $signed(mid + 1'b1) > $signed(hi_q);
              end
            end
          end else begin
            cmp_q <= sat1(cmp_q);
            if (rkey == key_q) begin
              hit_q <= 1'b1;
              pos_q <= lo_q[CntW-1:0];
              done_q <= 1'b1;
            end else begin
              lo_q <= lo_q + 1'b1;
              done_q <= (lo_q + 1'b1) >= {1'b0, count_q};
            end
          end
          if (mid[CntW-1:0] == count_q - CntW'(1) || lo_q[CntW-1:0] == count_q - CntW'(1)) begin
            if ((sorted_q ? mid[CntW-1:0] : lo_q[CntW-1:0]) == count_q - CntW'(1)) begin
              last_key_q <= rkey;
              have_last_q <= 1'b1;
            end
          end
        end
        OpApply: begin
          ok_q <= hit_q;
          if (cmd_q == CmdFind && hit_q) begin
            found_q <= rval_hold_q;
          end
          if (cmd_q != CmdFind) begin
            cmp_q <= '0;
          end
        end
        OpAddWrite: begin
          cmp_q <= '0;
          if (!hit_q && count_q != CntW'(Capacity)) begin
            if (16'(count_q) == size_q) begin
              size_q <= (17'(size_q) + 17'(step_i) > 17'hFFFF) ? 16'hFFFF
                        : size_q + 16'(step_i);
            end
            // a sorted miss that never probed the last slot saw a larger key first
            if (sorted_q && count_q != '0 && (!have_last_q || key_q < last_key_q)) begin
              sorted_q <= 1'b0;
            end
            count_q <= count_q + 1'b1;
            ok_q <= 1'b1;
          end
        end
        OpRmRead: cmp_q <= '0;
        OpRmWrite: begin
          count_q <= count_q - 1'b1;
          sorted_q <= 1'b0;
          ok_q <= 1'b1;
          if (size_q >= 16'(step_i) &&
              17'(count_q - CntW'(1)) < 17'(size_q - 16'(step_i))) begin
            size_q <= size_q - 16'(step_i);
          end
        end
        OpSortOuter: begin
          j_q <= i_q;
          if (i_q >= count_q || count_q == '0) begin
            sorted_q <= 1'b1;
            ok_q <= 1'b1;
          end
        end
        OpSortRead: begin
          if (j_q == i_q) begin
            // first pass: the element at i was read on OpSortOuter
            sk_q <= rkey;
            sv_q <= rval;
          end
        end
        OpSortEval: begin
          if (j_q != '0 && rkey > sk_q) begin
            cmp_q <= sat1(cmp_q);
            j_q <= j_q - 1'b1;
          end else begin
            if (j_q != '0) begin
              cmp_q <= sat1(cmp_q);
            end
            i_q <= i_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (dp_cmd_i.op == OpStart && cmd_i == CmdClear) begin
        count_q <= '0;
        size_q <= '0;
        ok_q <= 1'b1;
      end
    end
  end

  // a shift that reaches slot zero still needs the key placed there
  assign sts_o.cmd = cmd_q;
  assign sts_o.srch_done = done_q || (cmd_q == CmdAdd && count_q == CntW'(Capacity));
  assign sts_o.hit = hit_q;
  assign sts_o.sort_outer_done = (i_q >= count_q);
  assign sts_o.sort_shift = (j_q != '0) && (rkey > sk_q);

  assign ok_o = ok_q;
  assign entries_o = count_q;
  assign size_o = size_q;
  assign found_o = found_q;
  assign cmp_o = (cmd_q == CmdFind || cmd_q == CmdSort) ? cmp_q : 16'd0;
endmodule

/* rtl/keyed_record_table.sv */
// keyed record table top level: stream ports, apb registers and output register
// depends on krt_pkg, krt_ctrl, krt_dp (which uses krt_ram)
//
// channel  | dir | beat contents
// s_axis   | in  | tdata: cmd[2:0], key[34:3], owed_value[50:35], zero pad to 56 bits
// m_axis   | out | tdata: ok[0], entries[9:1], reported_size[25:10], found_value[41:26],
//          |     |        comparisons[57:42], zero pad to 64 bits
// apb      | in  | reg 0 initial_size at 0x0, reg 1 growth_step at 0x4
//
// one beat at a time: s_axis_tready is low while a command is in progress
// a search probe is a read then an evaluate step: linear walks probe up to entries slots,
// binary search up to log2(entries)+1; sort is insertion sort, a read and an evaluate step
// per compare plus an outer step per element, and another pair when a key lands in slot zero
// reset leaves an empty, sorted table with reported size 8 and step 4
// the result waits in an output register while the next beat is taken
module keyed_record_table import krt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // cmd, key, owed_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // ok, entries, reported_size, found_value, comparisons
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] init_size_q;
  logic [7:0]  step_q;
  logic        wr;
  krt_cmd_t    dp_cmd;
  krt_sts_t    sts;
  logic        busy, out_free;
  logic              ok;
  logic [CntW-1:0]   entries;
  logic [15:0]       size, found, cmp;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_size_q <= 16'd8;
      step_q <= 8'd4;
    end else if (wr) begin
      if (paddr[2] == RegGrowthStep[0]) begin
        step_q <= pwdata[7:0];
      end else begin
        init_size_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = paddr[2] ? {24'd0, step_q} : {16'd0, init_size_q};

  assign s_axis_tready = ~busy;
  // output register may hold the last result while the next command runs
  assign out_free = ~m_axis_tvalid || m_axis_tready;

  krt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(s_axis_tvalid && s_axis_tready), .out_free_i(out_free),
    .sts_i(sts), .dp_cmd_o(dp_cmd), .busy_o(busy));

  krt_dp u_dp (
    .clk_i, .rst_ni, .dp_cmd_i(dp_cmd), .cmd_i(s_axis_tdata[2:0]),
    .key_i(s_axis_tdata[34:3]), .val_i(s_axis_tdata[50:35]),
    .cfg_size_we_i(wr && paddr[2] == RegInitialSize[0]), .cfg_size_i(pwdata[15:0]),
    .step_i(step_q), .sts_o(sts), .ok_o(ok), .entries_o(entries), .size_o(size),
    .found_o(found), .cmp_o(cmp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
    end else begin
      if (dp_cmd.op == OpDone) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {6'd0, cmp, found, size, entries, ok};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end
endmodule

/* verif/krt_checker.sv */
// keyed record table checker: watches the apb port and both stream channels,
// predicts every result beat from its own copy of the table, compares field by field
// depends on krt_pkg for the command and register codes
module krt_checker import krt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          err_cnt_o,
  output int          owed_results_o
);

  typedef struct packed {
    logic        ok;
    logic [8:0]  entries;
    logic [15:0] size;
    logic [15:0] found;
    logic [15:0] cmps;
  } answer_t;

  answer_t     answers_q[$];
  logic [31:0] key_mem [Capacity];
  logic [15:0] val_mem [Capacity];
  int unsigned n_rec, rep_size, step, init_size;
  bit          in_order;
  int          errs;

  assign err_cnt_o      = errs;
  assign owed_results_o = answers_q.size();

  function automatic int unsigned sat16(int unsigned a);
    return (a > 65535) ? 65535 : a;
  endfunction

  // binary probe costs 1 on a hit, 2 on a miss; linear probe costs 1
  function automatic int lookup(logic [31:0] k, inout int unsigned cmps);
    int lo, hi, mid;
    lo = 0;
    hi = int'(n_rec) - 1;
    if (in_order) begin
      while (lo <= hi) begin
        mid  = lo + (hi - lo) / 2;
        cmps = sat16(cmps + 1);
        if (key_mem[mid] == k) return mid;
        cmps = sat16(cmps + 1);
        if (key_mem[mid] > k) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    end
    for (int i = 0; i < int'(n_rec); i++) begin
      cmps = sat16(cmps + 1);
      if (key_mem[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int unsigned insertion_sort();
    int unsigned cmps;
    int          j;
    logic [31:0] k;
    logic [15:0] v;
    cmps = 0;
    for (int i = 1; i < int'(n_rec); i++) begin
      k = key_mem[i];
      v = val_mem[i];
      j = i - 1;
      while (j >= 0 && key_mem[j] > k) begin
        cmps = sat16(cmps + 1);
        key_mem[j+1] = key_mem[j];
        val_mem[j+1] = val_mem[j];
        j--;
      end
      if (j >= 0) cmps = sat16(cmps + 1);
      key_mem[j+1] = k;
      val_mem[j+1] = v;
    end
    in_order = 1;
    return cmps;
  endfunction

  function automatic answer_t apply_command(logic [2:0] c, logic [31:0] k, logic [15:0] v);
    answer_t     a;
    int unsigned cmps, scratch, saved;
    int          pos;
    a = '0;
    cmps = 0;
    scratch = 0;
    case (c)
      CmdAdd: begin
        saved = rep_size;
        if (n_rec < Capacity) begin
          if (n_rec == rep_size) rep_size = sat16(rep_size + step);
          if (lookup(k, scratch) >= 0) begin
            rep_size = saved;
          end else begin
            key_mem[n_rec] = k;
            val_mem[n_rec] = v;
            if (in_order && n_rec > 0 && k < key_mem[n_rec-1]) in_order = 0;
            n_rec++;
            a.ok = 1;
          end
        end
      end
      CmdRemove: begin
        pos = lookup(k, scratch);
        if (pos >= 0) begin
          key_mem[pos] = key_mem[n_rec-1];
          val_mem[pos] = val_mem[n_rec-1];
          n_rec--;
          in_order = 0;
          if (rep_size >= step && n_rec < rep_size - step) rep_size -= step;
          a.ok = 1;
        end
      end
      CmdModify: begin
        pos = lookup(k, scratch);
        if (pos >= 0) begin
          val_mem[pos] = v;
          a.ok = 1;
        end
      end
      CmdFind: begin
        pos = lookup(k, cmps);
        if (pos >= 0) begin
          a.found = val_mem[pos];
          a.ok = 1;
        end
      end
      CmdSort: begin
        cmps = insertion_sort();
        a.ok = 1;
      end
      CmdClear: begin
        n_rec = 0;
        rep_size = 0;
        a.ok = 1;
      end
      default: ;
    endcase
    a.entries = 9'(n_rec);
    a.size    = 16'(rep_size);
    a.cmps    = 16'(cmps);
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want, got;
    if (!rst_ni) begin
      answers_q.delete();
      n_rec     = 0;
      init_size = 8;
      step      = 4;
      rep_size  = 8;
      in_order  = 1;
      errs      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (2'(paddr >> 2) == RegInitialSize) begin
          init_size = pwdata[15:0];
          rep_size  = init_size;
        end else if (2'(paddr >> 2) == RegGrowthStep) begin
          step = pwdata[7:0];
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        answers_q.push_back(apply_command(s_axis_tdata[2:0], s_axis_tdata[34:3],
                                          s_axis_tdata[50:35]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[9:1], m_axis_tdata[25:10],
               m_axis_tdata[41:26], m_axis_tdata[57:42]};
        if (answers_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          want = answers_q.pop_front();
          if (got != want || m_axis_tdata[63:58] != '0) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: exp ok %0d ent %0d size %0d found %0d cmp %0d, got ok %0d ent %0d size %0d found %0d cmp %0d",
                       want.ok, want.entries, want.size, want.found, want.cmps,
                       got.ok, got.entries, got.size, got.found, got.cmps);
          end
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
// keyed record table testbench top: clock, reset, apb writes, command stimulus, verdict
// depends on krt_pkg, keyed_record_table and krt_checker
module testbench import krt_pkg::*;;

  logic        clk_i, rst_ni;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [55:0] s_tdata;
  logic [63:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          err_cnt, owed;

  // stimulus mode: calm turns off idling on both sides, hold_req asks a long stall
  bit          calm;
  bit          hold_req;
  logic [31:0] key_pool [16];

  keyed_record_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  krt_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .err_cnt_o(err_cnt), .owed_results_o(owed)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // generous limit, far above the slowest legal run
  initial begin
    #60000000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random back-pressure, or a long counted hold-off on request
  initial begin
    m_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 0;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // one command beat; tvalid stays high into the next beat when sent back to back
  task automatic send_cmd(logic [2:0] c, logic [31:0] k, logic [15:0] v);
    while (!calm && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 0;
      @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata  <= {5'b0, v, k, c};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // drop valid and let every owed result drain
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx[0], 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 15)];
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return CmdAdd;
    if (r < 50) return CmdRemove;
    if (r < 60) return CmdModify;
    if (r < 85) return CmdFind;
    if (r < 92) return CmdSort;
    if (r < 95) return CmdClear;
    return 3'($urandom_range(6, 7));
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      calm = (i >= 30 && i < 60);
      if (i == 70) hold_req = 1;
      send_cmd(pick_cmd(), pick_key(), 16'($urandom()));
    end
    calm = 0;
  endtask

  // ascending adds keep the table sorted, so filling to capacity stays cheap
  task automatic fill_to_capacity();
    logic [31:0] k;
    send_cmd(CmdClear, '0, '0);
    k = 32'($urandom_range(0, 1000));
    for (int i = 0; i <= Capacity; i++) begin
      send_cmd(CmdAdd, k, 16'($urandom()));
      k = k + 32'($urandom_range(1, 1000));
    end
    send_cmd(CmdAdd, 32'd1, 16'hffff);
    send_cmd(CmdFind, k, '0);
    send_cmd(CmdRemove, 32'($urandom_range(0, 1000)), '0);
    send_cmd(CmdSort, '0, '0);
    send_cmd(CmdFind, '1, '0);
    send_cmd(CmdClear, '0, '0);
  endtask

  initial begin
    int unsigned sizes [5] = '{0, 65535, 8, 3, 100};
    int unsigned steps [5] = '{0, 255, 4, 1, 17};
    rst_ni   = 0;
    s_tvalid = 0;
    s_tdata  = '0;
    psel     = 0;
    penable  = 0;
    pwrite   = 0;
    paddr    = '0;
    pwdata   = '0;
    calm     = 0;
    hold_req = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes of key and value, duplicates, misses, order break, odd codes
    send_cmd(CmdFind, 32'h5, '0);
    send_cmd(CmdAdd, '0, '0);
    send_cmd(CmdAdd, '1, 16'hffff);
    send_cmd(CmdAdd, '1, 16'h1234);
    send_cmd(CmdAdd, 32'h8000_0000, 16'h8000);
    send_cmd(CmdFind, '1, '0);
    send_cmd(CmdFind, 32'h7fff_ffff, '0);
    send_cmd(CmdModify, '0, 16'h00ff);
    send_cmd(CmdModify, 32'h42, 16'h0001);
    send_cmd(CmdAdd, 32'h10, 16'h5555);
    send_cmd(CmdFind, 32'h10, '0);
    send_cmd(CmdFind, 32'h11, '0);
    send_cmd(CmdRemove, 32'h11, '0);
    send_cmd(CmdRemove, '0, '0);
    send_cmd(CmdSort, '0, '0);
    send_cmd(CmdFind, 32'h10, '0);
    send_cmd(CmdFind, '0, '0);
    send_cmd(3'd6, 32'h10, 16'haaaa);
    send_cmd(3'd7, '1, 16'hffff);
    send_cmd(CmdClear, '0, '0);
    send_cmd(CmdFind, 32'h10, '0);
    send_cmd(CmdSort, '0, '0);
    send_cmd(CmdRemove, '1, '0);

    // pause until everything is back, then run a random burst that holds off the receiver once
    drain();
    random_burst(100);
    drain();

    for (int p = 0; p < 5; p++) begin
      reg_write(RegInitialSize, sizes[p]);
      reg_write(RegGrowthStep, steps[p]);
      if (p == 2) fill_to_capacity();
      random_burst(25);
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && owed == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
